>>> sv/ordered_list_engine_macros.svh
// Assertion macros used by the ordered list engine datapath.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OLE_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("olist: invariant check failed");
`define OLE_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("olist: implication check failed");
`else
`define OLE_ASSERT(lbl, prop)
`define OLE_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> sv/olist_pkg.sv
// Shared constants, codes and controller/datapath structs for the ordered list engine.
`default_nettype none
package olist_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(DEPTH + 1);
   localparam int CMD_W  = 4;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 8;
   localparam int ST_W   = 3;
   localparam int FLD_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 4'd0,
      CMD_INS_END   = 4'd1,
      CMD_INS_POS   = 4'd2,
      CMD_DEL_FRONT = 4'd3,
      CMD_DEL_END   = 4'd4,
      CMD_DEL_POS   = 4'd5,
      CMD_DISPLAY   = 4'd6,
      CMD_SEARCH    = 4'd7,
      CMD_COUNT     = 4'd8
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_INV_POS   = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_BAD_CMD   = 3'd5
   } status_type;

   // command class as seen by the controller
   typedef enum logic [2:0] {
      CLS_INS,
      CLS_DEL,
      CLS_DISP,
      CLS_SRCH,
      CLS_OTHER
   } cls_type;

   // kind of result loaded into the output register
   typedef enum logic [1:0] {
      EM_STATUS,
      EM_FOUND,
      EM_ELEM
   } emit_type;

   typedef struct packed {
      logic     ready;
      logic     start;
      logic     rd;
      logic     wr_shift;
      logic     wr_item;
      logic     step;
      logic     cnt_upd;
      logic     set_nf;
      logic     emit;
      emit_type kind;
   } dp_ctl_type;

   typedef struct packed {
      logic    req_valid;
      cls_type cls;
      logic    err;
      logic    shift_done;
      logic    walk_done;
      logic    match;
      logic    last_elem;
      logic    rsp_free;
   } dp_sts_type;

   function automatic cls_type cmd_class(logic [CMD_W-1:0] c);
      cls_type r;
      case (c) inside
         CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS: r = CLS_INS;
         CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS: r = CLS_DEL;
         CMD_DISPLAY:                             r = CLS_DISP;
         CMD_SEARCH:                              r = CLS_SRCH;
         default:                                 r = CLS_OTHER;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/olist_if.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface olist_req_if;
   import olist_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic signed [VAL_W-1:0] item_value;
   logic [POS_W-1:0]        target_position;

   modport source (output valid, command, item_value, target_position, input ready);
   modport sink   (input valid, command, item_value, target_position, output ready);
endinterface

interface olist_rsp_if;
   import olist_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ST_W-1:0]         status;
   logic signed [VAL_W-1:0] element_value;
   logic [FLD_W-1:0]        element_position;
   logic [FLD_W-1:0]        element_count;
   logic                    last_result;

   modport source (output valid, status, element_value, element_position, element_count,
                   last_result, input ready);
   modport sink   (input valid, status, element_value, element_position, element_count,
                   last_result, output ready);
endinterface
`default_nettype wire

>>> sv/olist_dpath.sv
// Datapath: element memory, fill count, walk index and the result register.
`default_nettype none
`include "ordered_list_engine_macros.svh"
module olist_dpath (
   input  logic                clock,
   input  logic                reset,
   olist_req_if.sink           req,
   olist_rsp_if.source         rsp,
   input  olist_pkg::dp_ctl_type ctl,
   output olist_pkg::dp_sts_type sts
);
   import olist_pkg::*;

   logic [VAL_W-1:0]        mem [DEPTH];
   logic [CMD_W-1:0]        cmd_ff;
   logic [VAL_W-1:0]        val_ff;
   status_type              st_ff;
   status_type              st_in;
   logic [IDX_W-1:0]        tgt_ff;
   logic [IDX_W-1:0]        tgt_in;
   logic [IDX_W-1:0]        idx_ff;
   logic [IDX_W-1:0]        count_ff;
   logic [VAL_W-1:0]        rdata_ff;
   logic [IDX_W-1:0]        rd_idx;
   logic [IDX_W-1:0]        idx_next;
   logic                    load;
   logic                    empty;
   logic                    full;
   logic                    pos_zero;
   logic                    pos_ins_hi;
   logic                    pos_del_hi;
   cls_type                 cls;
   logic                    rsp_valid_ff;
   status_type              rsp_st_ff;
   logic [VAL_W-1:0]        rsp_val_ff;
   logic [FLD_W-1:0]        rsp_pos_ff;
   logic [FLD_W-1:0]        rsp_cnt_ff;
   logic                    rsp_last_ff;

   assign load     = req.valid & ctl.ready;
   assign req.ready = ctl.ready;
   assign cls      = cmd_class(cmd_ff);

   // check the command against the list as it stands at accept
   assign empty      = (count_ff == '0);
   assign full       = (count_ff >= IDX_W'(DEPTH));
   assign pos_zero   = (req.target_position == '0);
   assign pos_ins_hi = ({1'b0, req.target_position} > ((POS_W+1)'(count_ff) + (POS_W+1)'(1)));
   assign pos_del_hi = ({1'b0, req.target_position} > (POS_W+1)'(count_ff));

   always_comb begin
      st_in  = ST_OK;
      tgt_in = '0;
      case (req.command) inside
         CMD_INS_FRONT: begin
            if (full) st_in = ST_FULL;
         end
         CMD_INS_END: begin
            if (full) st_in = ST_FULL;
            tgt_in = count_ff;
         end
         CMD_INS_POS: begin
            if (pos_zero || pos_ins_hi) st_in = ST_INV_POS;
            else if (full)              st_in = ST_FULL;
            tgt_in = IDX_W'(req.target_position - POS_W'(1));
         end
         CMD_DEL_FRONT: begin
            if (empty) st_in = ST_EMPTY;
         end
         CMD_DEL_END: begin
            if (empty) st_in = ST_EMPTY;
            tgt_in = count_ff - IDX_W'(1);
         end
         CMD_DEL_POS: begin
            if (empty)                       st_in = ST_EMPTY;
            else if (pos_zero || pos_del_hi) st_in = ST_INV_POS;
            tgt_in = IDX_W'(req.target_position - POS_W'(1));
         end
         CMD_DISPLAY: begin
            if (empty) st_in = ST_EMPTY;
         end
         CMD_SEARCH, CMD_COUNT: st_in = ST_OK;
         default: st_in = ST_BAD_CMD;
      endcase
   end

   // read address: insert pulls from below, delete from above, walks read in place
   always_comb begin
      case (cls)
         CLS_INS: rd_idx = idx_ff - IDX_W'(1);
         CLS_DEL: rd_idx = idx_ff + IDX_W'(1);
         default: rd_idx = idx_ff;
      endcase
   end

   assign idx_next = (cls == CLS_INS) ? idx_ff - IDX_W'(1) : idx_ff + IDX_W'(1);

   // hold the accepted command
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= req.command;
         val_ff <= req.item_value;
         tgt_ff <= tgt_in;
      end
      if (load)            st_ff <= st_in;
      else if (ctl.set_nf) st_ff <= ST_NOT_FOUND;
   end

   // advance the walk index
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         case (cls)
            CLS_INS: idx_ff <= count_ff;
            CLS_DEL: idx_ff <= tgt_ff;
            default: idx_ff <= '0;
         endcase
      end else if (ctl.step) begin
         idx_ff <= idx_next;
      end
   end

   // update the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.cnt_upd) begin
         if (cls == CLS_INS) count_ff <= count_ff + IDX_W'(1);
         else                count_ff <= count_ff - IDX_W'(1);
      end
   end

   // element memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_shift)     mem[idx_ff[ADDR_W-1:0]] <= rdata_ff;
      else if (ctl.wr_item) mem[idx_ff[ADDR_W-1:0]] <= val_ff;
      if (ctl.rd)           rdata_ff <= mem[rd_idx[ADDR_W-1:0]];
   end

   // result register, free again once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_cnt_ff <= FLD_W'(count_ff);
         case (ctl.kind)
            EM_FOUND: begin
               rsp_st_ff   <= ST_OK;
               rsp_val_ff  <= '0;
               rsp_pos_ff  <= FLD_W'(idx_ff + IDX_W'(1));
               rsp_last_ff <= 1'b1;
            end
            EM_ELEM: begin
               rsp_st_ff   <= ST_OK;
               rsp_val_ff  <= rdata_ff;
               rsp_pos_ff  <= FLD_W'(idx_ff + IDX_W'(1));
               rsp_last_ff <= sts.last_elem;
            end
            default: begin
               rsp_st_ff   <= st_ff;
               rsp_val_ff  <= '0;
               rsp_pos_ff  <= '0;
               rsp_last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_st_ff;
   assign rsp.element_value    = rsp_val_ff;
   assign rsp.element_position = rsp_pos_ff;
   assign rsp.element_count    = rsp_cnt_ff;
   assign rsp.last_result      = rsp_last_ff;

   // status back to the controller
   assign sts.req_valid  = req.valid;
   assign sts.cls        = cls;
   assign sts.err        = (st_ff != ST_OK);
   assign sts.shift_done = (cls == CLS_INS) ? (idx_ff == tgt_ff)
                                            : ((idx_ff + IDX_W'(1)) >= count_ff);
   assign sts.walk_done  = (idx_ff == count_ff);
   assign sts.match      = (rdata_ff == val_ff);
   assign sts.last_elem  = ((idx_ff + IDX_W'(1)) == count_ff);
   assign sts.rsp_free   = ~rsp_valid_ff | rsp.ready;

   `OLE_ASSERT(a_cnt_max, count_ff <= IDX_W'(DEPTH))
   `OLE_ASSERT_IMPL(a_emit_free, ctl.emit, sts.rsp_free)
   `OLE_ASSERT_IMPL(a_rd_range, ctl.rd, rd_idx < count_ff)
   `OLE_ASSERT_IMPL(a_ins_room, ctl.wr_item, count_ff < IDX_W'(DEPTH))

endmodule
`default_nettype wire

>>> sv/olist_ctrl.sv
// Controller: sequences shifts, walks and result emission for each command.
`default_nettype none
module olist_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  olist_pkg::dp_sts_type sts,
   output olist_pkg::dp_ctl_type ctl
);
   import olist_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SHIFT_CHK,
      S_SHIFT_WR,
      S_WALK_CHK,
      S_WALK_CMP,
      S_FOUND,
      S_DISP_OUT,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and datapath commands
   always_comb begin
      ctl      = '0;
      ctl.kind = EM_STATUS;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            ctl.ready = 1'b1;
            if (sts.req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (sts.err || sts.cls == CLS_OTHER) begin
               state_in = S_FINISH;
            end else begin
               ctl.start = 1'b1;
               if (sts.cls == CLS_INS || sts.cls == CLS_DEL) state_in = S_SHIFT_CHK;
               else                                           state_in = S_WALK_CHK;
            end
         end
         S_SHIFT_CHK: begin
            if (sts.shift_done) begin
               ctl.wr_item = (sts.cls == CLS_INS);
               ctl.cnt_upd = 1'b1;
               state_in    = S_FINISH;
            end else begin
               ctl.rd   = 1'b1;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            ctl.wr_shift = 1'b1;
            ctl.step     = 1'b1;
            state_in     = S_SHIFT_CHK;
         end
         S_WALK_CHK: begin
            if (sts.walk_done) begin
               ctl.set_nf = 1'b1;
               state_in   = S_FINISH;
            end else begin
               ctl.rd   = 1'b1;
               state_in = S_WALK_CMP;
            end
         end
         S_WALK_CMP: begin
            if (sts.cls == CLS_SRCH) begin
               if (sts.match) begin
                  state_in = S_FOUND;
               end else begin
                  ctl.step = 1'b1;
                  state_in = S_WALK_CHK;
               end
            end else begin
               state_in = S_DISP_OUT;
            end
         end
         S_FOUND: begin
            ctl.kind = EM_FOUND;
            if (sts.rsp_free) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DISP_OUT: begin
            ctl.kind = EM_ELEM;
            if (sts.rsp_free) begin
               ctl.emit = 1'b1;
               ctl.step = 1'b1;
               state_in = sts.last_elem ? S_IDLE : S_WALK_CHK;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/ordered_list_engine.sv
// Ordered list of up to sixteen signed 32-bit values driven by a command channel.
//
// Commands come in on req_ch (command, item_value, target_position) and are
// accepted when valid and ready are both high; ready is high only while no
// command is in progress. Each command gives one or more results on rsp_ch
// (status, element_value, element_position, element_count, last_result), the
// final one marked by last_result. Display streams one result per element.
// Insert and delete move the elements from the target position to the end one
// at a time; search compares elements from the front until a match or the end
// of the list. The engine returns to idle, with ready high, as the final result
// loads. The element memory has registered read data, so every moved or
// inspected element is read in one state and used in a later one. Results sit
// in one output register; a new command is taken while an earlier result still
// waits, and a stalled receiver holds the engine at its next result.
// Synchronous reset empties the list and drops any pending result; memory
// contents are not cleared since only held entries are read.
`default_nettype none
module ordered_list_engine (
   input  logic        clock,
   input  logic        reset,
   olist_req_if.sink   req_ch,
   olist_rsp_if.source rsp_ch
);
   import olist_pkg::*;

   dp_ctl_type ctl;
   dp_sts_type sts;

   olist_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   olist_dpath u_dpath (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .ctl   (ctl),
      .sts   (sts)
   );

endmodule
`default_nettype wire
